// ===== hw/rtl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character lookup for the base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END_OK  = 2'd1,
    KIND_END_ERR = 2'd2
  } kind_t;

  localparam int unsigned ACC_W  = 12;
  localparam int unsigned HELD_W = 3;

  // One queue entry: everything one accepted character produces.
  typedef struct packed {
    logic       has_data;
    logic [7:0] data_byte;
    logic       has_end;
    logic       end_err;
  } b64d_entry_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // Map a raw byte to its six-bit value; valid is low outside the alphabet.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t    s;
    logic [7:0] d;
    s = '0;
    d = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h61 + 8'd26;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30 + 8'd52;
      s.valid = 1'b1;
      s.value = d[5:0];
    end else if (c == 8'h2D) begin
      s.valid = 1'b1;
      s.value = 6'd62;
    end else if (c == 8'h5F) begin
      s.valid = 1'b1;
      s.value = 6'd63;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, keeps the bit accumulator and pushes results to queue.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char,
  input  logic        in_final,
  output logic        push,
  output b64d_entry_t push_entry,
  input  logic        push_ready
);

  logic [ACC_W-1:0]  acc, acc_next;
  logic [HELD_W-1:0] held, held_next;
  logic [1:0]        cnt, cnt_next;
  logic              err, err_next;
  logic              accept;
  sextet_t           sx;
  logic [ACC_W-1:0]  left_mask;
  b64d_entry_t       ent;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  always_comb begin
    sx        = sextet_of(in_char);
    acc_next  = acc;
    held_next = held;
    cnt_next  = cnt + 2'd1;
    err_next  = err;
    ent       = '0;
    left_mask = '0;
    if (!sx.valid) begin
      err_next = 1'b1;
    end else begin
      acc_next = {acc[ACC_W-7:0], sx.value};
      if (held >= 3'd2) begin
        held_next     = held - 3'd2;
        ent.has_data  = !err;
        unique case (held_next)
          3'd0:    ent.data_byte = acc_next[7:0];
          3'd2:    ent.data_byte = acc_next[9:2];
          default: ent.data_byte = acc_next[11:4];
        endcase
      end else begin
        held_next = held + 3'd6;
      end
    end
    unique case (held_next)
      3'd2:    left_mask = 12'h003;
      3'd4:    left_mask = 12'h00F;
      3'd6:    left_mask = 12'h03F;
      default: left_mask = 12'h000;
    endcase
    if (in_final) begin
      ent.has_end = 1'b1;
      ent.end_err = err_next || (cnt_next == 2'd1) || ((acc_next & left_mask) != '0);
    end
    if (!ent.has_data) begin
      ent.data_byte = '0;
    end
  end

  assign push       = accept && (ent.has_data || ent.has_end);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
      cnt  <= '0;
      err  <= 1'b0;
    end else if (accept) begin
      if (in_final) begin
        acc  <= '0;
        held <= '0;
        cnt  <= '0;
        err  <= 1'b0;
      end else begin
        acc  <= acc_next;
        held <= held_next;
        cnt  <= cnt_next;
        err  <= err_next;
      end
    end
  end

endmodule

// ===== hw/rtl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Small FIFO of result entries between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  b64d_entry_t push_entry,
  output logic        push_ready,
  input  logic        pop,
  output b64d_entry_t pop_entry,
  output logic        pop_valid
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64d_entry_t       mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Drains queue entries into the registered output stream, one transfer per byte or end status.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  b64d_entry_t pop_entry,
  input  logic        pop_valid,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output kind_t       out_kind,
  output logic        out_last
);

  logic end_pend;
  logic end_pend_err;
  logic out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = out_free && !end_pend && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      end_pend     <= 1'b0;
      end_pend_err <= 1'b0;
      out_byte     <= '0;
      out_kind     <= KIND_DATA;
      out_last     <= 1'b0;
    end else if (out_free) begin
      if (end_pend) begin
        // second half of an entry that carried both a byte and an end
        out_valid <= 1'b1;
        out_byte  <= '0;
        out_kind  <= end_pend_err ? KIND_END_ERR : KIND_END_OK;
        out_last  <= 1'b1;
        end_pend  <= 1'b0;
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        if (pop_entry.has_data) begin
          out_byte     <= pop_entry.data_byte;
          out_kind     <= KIND_DATA;
          out_last     <= 1'b0;
          end_pend     <= pop_entry.has_end;
          end_pend_err <= pop_entry.end_err;
        end else begin
          out_byte <= '0;
          out_kind <= pop_entry.end_err ? KIND_END_ERR : KIND_END_OK;
          out_last <= 1'b1;
        end
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/base64url_strict_decoder_core.sv =====
// ----------------------------------------------------------------------------
// base64url_strict_decoder_core
// Unpadded base64url decoder: one character in, decoded bytes and an end
// status (ok or error) out.
// ----------------------------------------------------------------------------
// Path: a character's results go through the queue, then the output register.
// Throughput: one character per cycle while the queue has room; the output
//   gives one transfer per cycle while m_tready is high, so a character with
//   both a byte and an end status needs two transfers. The output register
//   sets the result rate.
// Reset: rst synchronous, active high; clears decoder state, queue and output.
// ----------------------------------------------------------------------------
module base64url_strict_decoder_core
  import b64d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] code_char
  input  logic       s_tlast,   // final_char
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data_byte
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast    // run_end
);

  // Front -> queue
  logic        push;
  logic        push_ready;
  b64d_entry_t push_entry;
  // Queue -> back
  logic        pop;
  logic        pop_valid;
  b64d_entry_t pop_entry;
  kind_t       out_kind;

  // Front: classifies each character, updates the accumulator, length count
  // and sticky error, and writes what the character produced into the queue.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_char    (s_tdata),
    .in_final   (s_tlast),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  // Queue lets the input keep flowing while the output is stalled.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid)
  );

  // Back: splits an entry into a data transfer and/or an end transfer.
  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_kind  (out_kind),
    .out_last  (m_tlast)
  );

  assign m_tuser = out_kind;

endmodule

// ===== sim/tb_base64url_strict_decoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_base64url_strict_decoder_core
// Stream-level check of the base64url decoder. Texts go in one character per
// transfer. Each accepted character runs through a local decode model, and
// the bytes and end status that the model gives are queued. Every output
// transfer is compared against the oldest queued entry. The run has short
// directed texts, then random texts under three idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_base64url_strict_decoder_core;
  import b64d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    kind_t      kind;
    logic       run_end;
  } decoded_result_t;

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] code_char
  logic       s_tlast;   // final_char
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] data_byte
  logic [1:0] m_tuser;   // [1:0] kind
  logic       m_tlast;   // run_end

  // decode model state
  logic [11:0] acc_bits;
  int          held_count;
  logic [1:0]  char_mod4;
  logic        text_error;

  decoded_result_t pending_results[$];
  logic [7:0]      text_buf[$];

  int          fail_count;
  int          chars_sent;
  int          send_idle_pct;
  int          recv_idle_pct;
  int unsigned cycle_count;

  base64url_strict_decoder_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    m_tready = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver backpressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // raw byte -> 6-bit value, bit 6 set when outside the alphabet
  function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
    if (c == "-") return 7'd62;
    if (c == "_") return 7'd63;
    return 7'h40;
  endfunction

  function automatic logic [7:0] alphabet_char(input logic [5:0] v);
    if (v < 6'd26) return 8'("A") + 8'(v);
    if (v < 6'd52) return 8'("a") + 8'(v - 6'd26);
    if (v < 6'd62) return 8'("0") + 8'(v - 6'd52);
    if (v == 6'd62) return 8'("-");
    return 8'("_");
  endfunction

  // append at the tail of the expected-result queue
  task automatic queue_result(input decoded_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // append one character to the text being built
  task automatic add_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic clear_decode_state();
    acc_bits = '0;
    held_count = 0;
    char_mod4 = '0;
    text_error = 1'b0;
  endtask

  // Model one accepted character and queue what it yields.
  task automatic decode_char(input logic [7:0] c, input logic last);
    logic [6:0]      sv;
    decoded_result_t r;
    logic            bad;
    char_mod4 = char_mod4 + 2'd1;
    sv = sextet_lookup(c);
    if (sv[6]) begin
      // invalid char: counted, but the accumulator is left alone
      text_error = 1'b1;
    end else begin
      acc_bits = {acc_bits[5:0], sv[5:0]};
      held_count += 6;
      if (held_count >= 8) begin
        held_count -= 8;
        if (!text_error) begin
          r.data_byte = 8'(acc_bits >> held_count);
          r.kind = KIND_DATA;
          r.run_end = 1'b0;
          queue_result(r);
        end
      end
    end
    if (last) begin
      bad = text_error || (char_mod4 == 2'd1);
      if (held_count > 0 && (acc_bits & ((12'd1 << held_count) - 12'd1)) != 12'd0) begin
        bad = 1'b1;
      end
      r.data_byte = 8'h00;
      r.kind = bad ? KIND_END_ERR : KIND_END_OK;
      r.run_end = 1'b1;
      queue_result(r);
      clear_decode_state();
    end
  endtask

  // Input and output transfers are both seen here, at the rising edge.
  always @(posedge clk) begin
    decoded_result_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_char(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: data_byte %0h kind %0d run_end %0b",
                 m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          r = pending_results.pop_front();
          if (m_tdata !== r.data_byte) begin
            $error("data_byte mismatch: expected %0h, actual %0h", r.data_byte, m_tdata);
            fail_count++;
          end
          if (m_tuser !== r.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", r.kind, m_tuser);
            fail_count++;
          end
          if (m_tlast !== r.run_end) begin
            $error("run_end mismatch: expected %0b, actual %0b", r.run_end, m_tlast);
            fail_count++;
          end
        end
      end
    end
  end

  // One character transfer, with random sender gaps ahead of it.
  task automatic send_char(input logic [7:0] c, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      send_char(text_buf[i], i == text_buf.size() - 1);
    end
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  // 'A' and '_' are the value extremes, '9' and '-' the other ranges' tops
  task automatic test_alphabet_extremes();
    load_text("A_9-");
    send_text();
    load_text("z");          // one char: always an error
    send_text();
  endtask

  // leftover bits: zero for QQ and QQQ, nonzero for QR
  task automatic test_leftover_bits();
    load_text("QQ");
    send_text();
    load_text("QR");
    send_text();
    load_text("QQQ");
    send_text();
  endtask

  task automatic test_bad_length();
    load_text("AAAAA");
    send_text();
  endtask

  // invalid bytes, then valid chars after the error: no bytes may appear
  task automatic test_invalid_chars();
    text_buf.delete();
    add_char(8'h00);
    add_char("+");
    add_char("Q");
    add_char("/");
    add_char("=");
    add_char("Q");
    add_char("Q");
    add_char(8'hFF);
    send_text();
  endtask

  // Mostly well-formed texts with random content; the rest broken on purpose.
  task automatic make_random_text();
    int         mix;
    int         len;
    int         pos;
    logic [5:0] sx;
    text_buf.delete();
    mix = $urandom_range(0, 99);
    if (mix >= 92) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) add_char(8'($urandom_range(0, 255)));
    end else begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      if (len % 4 == 1) len++;
      for (int i = 0; i < len; i++) begin
        sx = 6'($urandom_range(0, 63));
        // clean tail: unused low bits of the last char are zero
        if (i == len - 1) begin
          if (len % 4 == 2) sx &= 6'h30;
          if (len % 4 == 3) sx &= 6'h3C;
        end
        add_char(alphabet_char(sx));
      end
      if (mix >= 70 && mix < 78) begin
        pos = $urandom_range(0, len - 1);
        text_buf[pos] = 8'($urandom_range(0, 255));
      end else if (mix >= 78 && mix < 86 && len % 4 != 0) begin
        sx = {5'($urandom_range(0, 31)), 1'b1};
        text_buf[len - 1] = alphabet_char(sx);
      end else if (mix >= 78) begin
        while (text_buf.size() % 4 != 1) begin
          add_char(alphabet_char(6'($urandom_range(0, 63))));
        end
      end
    end
  endtask

  task automatic test_random_texts(input int count);
    int start;
    start = chars_sent;
    while (chars_sent - start < count) begin
      make_random_text();
      send_text();
    end
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    fail_count = 0;
    chars_sent = 0;
    send_idle_pct = 34;
    recv_idle_pct = 65;
    clear_decode_state();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_alphabet_extremes();
    test_leftover_bits();
    test_bad_length();
    test_invalid_chars();
    test_random_texts(550);

    send_idle_pct = 65;
    recv_idle_pct = 34;
    test_random_texts(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_texts(550);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
